// File: hdl/cpte_pkg.sv
// Shared types and constants for the code point text encoder.
`default_nettype none
package cpte_pkg;

  localparam int CP_W        = 21;
  localparam int BYTE_W      = 8;
  localparam int MAX_BYTES   = 4;
  localparam int IDX_W       = 2;
  localparam int REG_DATA_W  = 2;
  localparam int REG_INDEX_W = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_LATIN = 2'd0,
    MODE_UTF8  = 2'd1,
    MODE_UTF16 = 2'd2,
    MODE_ALT16 = 2'd3
  } cpte_mode_t;

  localparam logic [REG_INDEX_W-1:0] REG_ENCODING_MODE = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_CRLF_ENABLE   = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_UTF16_LE      = 2'd2;

  localparam logic [CP_W-1:0]   NEWLINE_CP     = 21'h00000A;
  localparam logic [BYTE_W-1:0] CR_CODE        = 8'd13;
  localparam logic [15:0]       CR_UNIT        = 16'd13;
  localparam logic [15:0]       REPLACEMENT_CP = 16'hFFFD;
  localparam logic [CP_W-1:0]   ONE_BYTE_MAX   = 21'h00007F;
  localparam logic [CP_W-1:0]   TWO_BYTE_MAX   = 21'h0007FF;
  localparam logic [CP_W-1:0]   BMP_MAX        = 21'h00FFFF;
  localparam logic [CP_W-1:0]   UNICODE_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE      = 21'h010000;
  localparam logic [15:0]       HIGH_SURR      = 16'hD800;
  localparam logic [15:0]       LOW_SURR       = 16'hDC00;
  localparam logic [BYTE_W-1:0] LEAD2          = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3          = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4          = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT           = 8'h80;

  typedef struct packed {
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]                 last_idx;
  } cpte_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cpte_qstat_t;

endpackage
`default_nettype wire

// File: hdl/cpte_front.sv
// Front end: configuration registers and classification of a code point into its bytes.
`default_nettype none
module cpte_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               wr_en,
  input  wire logic [cpte_pkg::REG_INDEX_W-1:0]   wr_index,
  input  wire logic [cpte_pkg::REG_DATA_W-1:0]    wr_data,
  input  wire logic [cpte_pkg::CP_W-1:0]          code_point,
  output cpte_pkg::cpte_entry_t                   entry
);
  import cpte_pkg::*;

  cpte_mode_t encoding_mode;
  logic       crlf_enable;
  logic       utf16_little_endian;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode       <= MODE_UTF8;
      crlf_enable         <= 1'b0;
      utf16_little_endian <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENCODING_MODE: encoding_mode       <= cpte_mode_t'(wr_data);
        REG_CRLF_ENABLE:   crlf_enable         <= wr_data[0];
        REG_UTF16_LE:      utf16_little_endian <= wr_data[0];
        default: ;
      endcase
    end
  end

  logic            cr;
  logic [CP_W-1:0] supp;
  logic [15:0]     u0;
  logic [15:0]     u1;
  logic            two_units;

  always_comb begin
    cr        = (code_point == NEWLINE_CP) && crlf_enable;
    supp      = code_point - SUPP_BASE;
    u0        = '0;
    u1        = '0;
    two_units = 1'b0;
    entry     = '0;
    case (encoding_mode)
      MODE_LATIN: begin
        if (cr) begin
          entry.bytes[0] = CR_CODE;
          entry.bytes[1] = code_point[7:0];
          entry.last_idx = 2'd1;
        end else begin
          entry.bytes[0] = code_point[7:0];
          entry.last_idx = 2'd0;
        end
      end
      MODE_UTF8: begin
        if (code_point <= ONE_BYTE_MAX) begin
          if (cr) begin
            entry.bytes[0] = CR_CODE;
            entry.bytes[1] = code_point[7:0];
            entry.last_idx = 2'd1;
          end else begin
            entry.bytes[0] = code_point[7:0];
            entry.last_idx = 2'd0;
          end
        end else if (code_point <= TWO_BYTE_MAX) begin
          entry.bytes[0] = LEAD2 | {3'b000, code_point[10:6]};
          entry.bytes[1] = CONT | {2'b00, code_point[5:0]};
          entry.last_idx = 2'd1;
        end else if (code_point <= BMP_MAX) begin
          entry.bytes[0] = LEAD3 | {4'b0000, code_point[15:12]};
          entry.bytes[1] = CONT | {2'b00, code_point[11:6]};
          entry.bytes[2] = CONT | {2'b00, code_point[5:0]};
          entry.last_idx = 2'd2;
        end else begin
          entry.bytes[0] = LEAD4 | {5'b00000, code_point[20:18]};
          entry.bytes[1] = CONT | {2'b00, code_point[17:12]};
          entry.bytes[2] = CONT | {2'b00, code_point[11:6]};
          entry.bytes[3] = CONT | {2'b00, code_point[5:0]};
          entry.last_idx = 2'd3;
        end
      end
      default: begin
        if (cr) begin
          u0        = CR_UNIT;
          u1        = code_point[15:0];
          two_units = 1'b1;
        end else if (code_point <= BMP_MAX) begin
          u0 = code_point[15:0];
        end else if (code_point <= UNICODE_MAX) begin
          u0        = HIGH_SURR | {6'b000000, supp[19:10]};
          u1        = LOW_SURR | {6'b000000, supp[9:0]};
          two_units = 1'b1;
        end else begin
          u0 = REPLACEMENT_CP;
        end
        if (utf16_little_endian) begin
          entry.bytes[0] = u0[7:0];
          entry.bytes[1] = u0[15:8];
          entry.bytes[2] = u1[7:0];
          entry.bytes[3] = u1[15:8];
        end else begin
          entry.bytes[0] = u0[15:8];
          entry.bytes[1] = u0[7:0];
          entry.bytes[2] = u1[15:8];
          entry.bytes[3] = u1[7:0];
        end
        entry.last_idx = two_units ? 2'd3 : 2'd1;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/cpte_queue.sv
// Short queue of classified entries between front and back.
`default_nettype none
module cpte_queue #(
  parameter int DEPTH = cpte_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire cpte_pkg::cpte_entry_t  push_entry,
  input  wire logic                   pop,
  output cpte_pkg::cpte_entry_t       head,
  output cpte_pkg::cpte_qstat_t       stat
);
  import cpte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cpte_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/cpte_back.sv
// Back end: sends the bytes of each entry, one per cycle, through registered outputs.
`default_nettype none
module cpte_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cpte_pkg::cpte_entry_t         head,
  input  wire cpte_pkg::cpte_qstat_t         stat,
  output logic                               pop,
  output logic                               strobe,
  output logic [cpte_pkg::BYTE_W-1:0]        out_byte,
  output logic                               last_byte
);
  import cpte_pkg::*;

  cpte_entry_t      cur;
  logic             active;
  logic [IDX_W-1:0] idx;
  logic             at_end;

  assign at_end = (idx == cur.last_idx);
  assign pop    = (!active || at_end) && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active && at_end) begin
        active <= 1'b0;
      end else if (active) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte  <= cur.bytes[idx];
    last_byte <= at_end;
    if (pop) begin
      cur <= head;
    end
  end

endmodule
`default_nettype wire

// File: hdl/code_point_text_encoder.sv
// Top level of the code point text encoder.
//
//   channel   ports                                  transfer
//   input     start, busy, code_point                start && !busy
//   result    strobe, out_byte, last_byte            strobe, one cycle each
//   config    wr_en, wr_index, wr_data               wr_en
//
// One result byte per cycle while an item is being sent; an item has 1 to 4 bytes,
// all sent through the back end's single byte lane.
// A new item may be taken every cycle while the two-entry queue has room.
// When idle, a taken item passes the queue and the back end's entry register before its first byte.
// Reset clears the queue, the back end and the registers to UTF-8, no CR, big-endian.
// busy rises only when the queue is full; the result side never stalls.
`default_nettype none
module code_point_text_encoder #(
  parameter int QUEUE_DEPTH = cpte_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [cpte_pkg::CP_W-1:0]          code_point,
  output logic                                    strobe,
  output logic [cpte_pkg::BYTE_W-1:0]             out_byte,
  output logic                                    last_byte,
  input  wire logic                               wr_en,
  input  wire logic [cpte_pkg::REG_INDEX_W-1:0]   wr_index,
  input  wire logic [cpte_pkg::REG_DATA_W-1:0]    wr_data
);
  import cpte_pkg::*;

  cpte_entry_t  entry;
  cpte_entry_t  head;
  cpte_qstat_t  stat;
  logic         pop;

  assign busy = stat.full;

  cpte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .code_point (code_point),
    .entry      (entry)
  );

  cpte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (start),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  cpte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .strobe    (strobe),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule
`default_nettype wire

// File: verif/code_point_encoding_checker.sv
// Checker for the code point text encoder: tracks registers, predicts bytes, compares results.
`timescale 1ns / 1ps
module code_point_encoding_checker
  import cpte_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   busy,
  input  wire logic [CP_W-1:0]        code_point,
  input  wire logic                   strobe,
  input  wire logic [BYTE_W-1:0]      out_byte,
  input  wire logic                   last_byte,
  input  wire logic                   wr_en,
  input  wire logic [REG_INDEX_W-1:0] wr_index,
  input  wire logic [REG_DATA_W-1:0]  wr_data,
  output int                          fail_count,
  output int                          bytes_outstanding,
  output int                          code_points_taken,
  output int                          bytes_checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } encoded_byte_t;

  encoded_byte_t expected_bytes[$];
  cpte_mode_t    cfg_mode;
  logic          cfg_crlf;
  logic          cfg_le;

  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    encoded_byte_t eb;
    eb.value = b;
    eb.last  = 1'b0;
    expected_bytes.push_back(eb);
  endfunction

  function automatic void push_unit(input logic [15:0] u);
    if (cfg_le) begin
      push_byte(u[7:0]);
      push_byte(u[15:8]);
    end else begin
      push_byte(u[15:8]);
      push_byte(u[7:0]);
    end
  endfunction

  function automatic void predict_encoding(input logic [CP_W-1:0] cp);
    logic             cr;
    logic [CP_W-1:0]  offset;
    encoded_byte_t    tail;
    cr = (cp == NEWLINE_CP) && cfg_crlf;
    case (cfg_mode)
      MODE_LATIN: begin
        if (cr) push_byte(CR_CODE);
        push_byte(cp[7:0]);
      end
      MODE_UTF8: begin
        if (cp <= ONE_BYTE_MAX) begin
          if (cr) push_byte(CR_CODE);
          push_byte(cp[7:0]);
        end else if (cp <= TWO_BYTE_MAX) begin
          push_byte({3'b110, cp[10:6]});
          push_byte({2'b10, cp[5:0]});
        end else if (cp <= BMP_MAX) begin
          push_byte({4'b1110, cp[15:12]});
          push_byte({2'b10, cp[11:6]});
          push_byte({2'b10, cp[5:0]});
        end else begin
          push_byte({5'b11110, cp[20:18]});
          push_byte({2'b10, cp[17:12]});
          push_byte({2'b10, cp[11:6]});
          push_byte({2'b10, cp[5:0]});
        end
      end
      default: begin
        if (cr) push_unit(CR_UNIT);
        if (cp <= BMP_MAX) begin
          push_unit(cp[15:0]);
        end else if (cp <= UNICODE_MAX) begin
          offset = cp - SUPP_BASE;
          push_unit(HIGH_SURR | {6'd0, offset[19:10]});
          push_unit(LOW_SURR | {6'd0, offset[9:0]});
        end else begin
          push_unit(REPLACEMENT_CP);
        end
      end
    endcase
    tail = expected_bytes.pop_back();
    tail.last = 1'b1;
    expected_bytes.push_back(tail);
  endfunction

  always @(posedge clk) begin
    encoded_byte_t exp_byte;
    if (rst) begin
      cfg_mode = MODE_UTF8;
      cfg_crlf = 1'b0;
      cfg_le   = 1'b0;
      expected_bytes.delete();
    end else begin
      if (wr_en === 1'b1) begin
        case (wr_index)
          REG_ENCODING_MODE: cfg_mode = cpte_mode_t'(wr_data);
          REG_CRLF_ENABLE:   cfg_crlf = wr_data[0];
          REG_UTF16_LE:      cfg_le   = wr_data[0];
          default: ;
        endcase
      end
      if (start === 1'b1 && busy === 1'b0) begin
        predict_encoding(code_point);
        code_points_taken++;
      end
      if (strobe === 1'b1) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected byte %02h last %0b, nothing expected",
                   $realtime, out_byte, last_byte);
        end else begin
          exp_byte = expected_bytes.pop_front();
          bytes_checked++;
          if (out_byte !== exp_byte.value) begin
            fail_count++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $realtime, exp_byte.value, out_byte);
          end
          if (last_byte !== exp_byte.last) begin
            fail_count++;
            $display("%0t: last_byte expected %0b actual %0b",
                     $realtime, exp_byte.last, last_byte);
          end
        end
      end
    end
    bytes_outstanding = expected_bytes.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the code point text encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import cpte_pkg::*;

  localparam int                     MAX_CYCLES   = 100000;
  localparam int                     RANDOM_ROUNDS = 12;
  localparam int                     ROUND_ITEMS  = 28;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE    = 2'd3;
  localparam logic [CP_W-1:0]        EDGE_CODES [7] = '{
    21'h000000, 21'h00000A, 21'h00010A, 21'h000080,
    21'h00D800, 21'h10FFFF, 21'h1FFFFF
  };

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [CP_W-1:0]        code_point;
  logic                   strobe;
  logic [BYTE_W-1:0]      out_byte;
  logic                   last_byte;
  logic                   wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [REG_DATA_W-1:0]  wr_data;

  int fail_count;
  int bytes_outstanding;
  int code_points_taken;
  int bytes_checked;
  int burst_left;
  int settings_applied;
  int cycle_count;

  code_point_text_encoder DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .code_point (code_point),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .last_byte  (last_byte),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  code_point_encoding_checker encoding_check (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .code_point        (code_point),
    .strobe            (strobe),
    .out_byte          (out_byte),
    .last_byte         (last_byte),
    .wr_en             (wr_en),
    .wr_index          (wr_index),
    .wr_data           (wr_data),
    .fail_count        (fail_count),
    .bytes_outstanding (bytes_outstanding),
    .code_points_taken (code_points_taken),
    .bytes_checked     (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("code_point_text_encoder test failed");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge with start still high.
  task automatic send_code(input logic [CP_W-1:0] cp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start      <= 1'b1;
    code_point <= cp;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    while (bytes_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Spare bit of the one-bit registers and the unused index get random data.
  task automatic apply_settings(input cpte_mode_t mode, input logic crlf,
                                input logic le);
    wr_en    <= 1'b1;
    wr_index <= REG_ENCODING_MODE;
    wr_data  <= mode;
    @(negedge clk);
    wr_index <= REG_CRLF_ENABLE;
    wr_data  <= {1'($urandom_range(0, 1)), crlf};
    @(negedge clk);
    wr_index <= REG_UTF16_LE;
    wr_data  <= {1'($urandom_range(0, 1)), le};
    @(negedge clk);
    wr_index <= REG_SPARE;
    wr_data  <= 2'($urandom_range(0, 3));
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
    settings_applied++;
  endtask

  initial begin
    logic [CP_W-1:0] cp;
    rst        = 1'b1;
    start      = 1'b0;
    code_point = '0;
    wr_en      = 1'b0;
    wr_index   = '0;
    wr_data    = '0;
    burst_left = 0;
    settings_applied = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Boundary and special code points under reset settings, then other modes.
    for (int g = 0; g < 4; g++) begin
      case (g)
        1: apply_settings(MODE_LATIN, 1'b1, 1'b0);
        2: apply_settings(MODE_UTF16, 1'b1, 1'b1);
        3: apply_settings(MODE_ALT16, 1'b1, 1'b0);
        default: ;
      endcase
      foreach (EDGE_CODES[i]) send_code(EDGE_CODES[i]);
      drain_results();
    end

    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      apply_settings(cpte_mode_t'(r % 4), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0: cp = NEWLINE_CP;
          1: cp = {13'($urandom), 8'h0A};
          2: cp = 21'($urandom_range(0, 'h7F));
          3: cp = 21'($urandom_range('h80, 'h7FF));
          4: cp = 21'($urandom_range('h800, 'hFFFF));
          5: cp = 21'($urandom_range('hD800, 'hDFFF));
          6: cp = 21'($urandom_range('h10000, 'h10FFFF));
          7: cp = 21'($urandom_range('h110000, 'h1FFFFF));
          default: cp = 21'($urandom);
        endcase
        send_code(cp);
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d code points over %0d register settings, %0d bytes compared",
             code_points_taken, settings_applied + 1, bytes_checked);
    if (fail_count == 0) begin
      $display("code_point_text_encoder test passed");
    end else begin
      $display("code_point_text_encoder test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/cpte_pkg.sv
hdl/cpte_front.sv
hdl/cpte_queue.sv
hdl/cpte_back.sv
hdl/code_point_text_encoder.sv
verif/code_point_encoding_checker.sv
verif/testbench.sv
